>>> design/sswe_pkg.sv
package sswe_pkg;

  localparam int STEPS = 20;
  localparam int PITCH_ROWS = 4;
  localparam int STEP_AW = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int ROW_AW = (PITCH_ROWS > 1) ? $clog2(PITCH_ROWS) : 1;
  localparam int CELL_W = 8;
  localparam int CFG_IDX_W = 8;

  localparam logic [7:0] PITCH_RESET [4] = '{8'd187, 8'd198, 8'd222, 8'd254};

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_UP     = 3'd1,
    OP_DOWN   = 3'd2,
    OP_LEFT   = 3'd3,
    OP_RIGHT  = 3'd4,
    OP_TOGGLE = 3'd5,
    OP_PLAY   = 3'd6,
    OP_CLEAR  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic latch;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } status_t;

endpackage

>>> design/sswe_if.sv
interface sswe_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] tempo;
  modport source (output valid, output operation, output tempo, input ready);
  modport sink (input valid, input operation, input tempo, output ready);
endinterface

interface sswe_out_if;
  logic       valid;
  logic       ready;
  logic       tone_enable;
  logic [7:0] tone_period;
  logic [6:0] tone_duty;
  logic [4:0] step_index;
  logic [4:0] cursor_column;
  logic [1:0] cursor_row;
  logic       is_playing;
  modport source (output valid, output tone_enable, output tone_period, output tone_duty,
                  output step_index, output cursor_column, output cursor_row,
                  output is_playing, input ready);
  modport sink (input valid, input tone_enable, input tone_period, input tone_duty,
                input step_index, input cursor_column, input cursor_row,
                input is_playing, output ready);
endinterface

interface sswe_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/sswe_ram.sv
module sswe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/sswe_ctrl.sv
module sswe_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sswe_pkg::status_t status,
  output sswe_pkg::cmd_t   cmd
);

  sswe_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sswe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    cmd = '0;
    case (state)
      sswe_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_next = sswe_pkg::ST_READ;
        end
      end
      sswe_pkg::ST_READ: begin
        state_next = sswe_pkg::ST_EXEC;
      end
      sswe_pkg::ST_EXEC: begin
        if (!status.out_full) begin
          cmd.commit = 1'b1;
          state_next = sswe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sswe_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/sswe_dp.sv
module sswe_dp (
  input  logic              clk,
  input  logic              rst,
  input  sswe_pkg::cmd_t    cmd,
  output sswe_pkg::status_t status,
  input  logic [2:0]        in_operation,
  input  logic [7:0]        in_tempo,
  input  logic              cfg_valid,
  input  logic [7:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              tone_enable,
  output logic [7:0]        tone_period,
  output logic [6:0]        tone_duty,
  output logic [4:0]        step_index,
  output logic [4:0]        cursor_column,
  output logic [1:0]        cursor_row,
  output logic              is_playing
);

  localparam int AW = sswe_pkg::STEP_AW;
  localparam int RW = sswe_pkg::ROW_AW;

  sswe_pkg::op_t op;
  logic [7:0] tempo;
  logic [7:0] pitch [sswe_pkg::PITCH_ROWS];
  logic [sswe_pkg::STEPS-1:0] cell_valid;
  logic [4:0] current_step;
  logic [7:0] tick_counter;
  logic [4:0] cursor_col_reg;
  logic [1:0] cursor_row_reg;
  logic play_flag;
  logic tone_on;
  logic [7:0] period_reg;

  logic [4:0] step_after;
  logic [AW-1:0] raddr;
  logic [7:0] rdata;
  logic [7:0] cell_data;
  logic [7:0] row_pitch;
  logic [7:0] toggled;
  logic cell_we;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op <= sswe_pkg::op_t'(in_operation);
      tempo <= in_tempo;
    end
  end

  // pitch registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sswe_pkg::PITCH_ROWS; i++) begin
        pitch[i] <= sswe_pkg::PITCH_RESET[i];
      end
    end else if (cfg_valid && cfg_index < 8'(sswe_pkg::PITCH_ROWS)) begin
      pitch[cfg_index[RW-1:0]] <= cfg_data;
    end
  end

  assign step_after = (current_step == 5'(sswe_pkg::STEPS - 1)) ? 5'd0 : current_step + 5'd1;
  assign raddr = (op == sswe_pkg::OP_TICK) ? step_after[AW-1:0] : cursor_col_reg[AW-1:0];
  assign cell_data = cell_valid[raddr] ? rdata : 8'd0;
  assign row_pitch = pitch[cursor_row_reg[RW-1:0]];
  assign toggled = (cell_data == row_pitch) ? 8'd0 : row_pitch;
  assign cell_we = cmd.commit && (op == sswe_pkg::OP_TOGGLE);

  sswe_ram #(
    .WIDTH(sswe_pkg::CELL_W),
    .DEPTH(sswe_pkg::STEPS)
  ) u_cells (
    .clk  (clk),
    .we   (cell_we),
    .waddr(cursor_col_reg[AW-1:0]),
    .wdata(toggled),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= '0;
      current_step <= 5'd0;
      tick_counter <= 8'd0;
      cursor_col_reg <= 5'd0;
      cursor_row_reg <= 2'd0;
      play_flag <= 1'b1;
      tone_on <= 1'b0;
      period_reg <= 8'd0;
    end else if (cmd.commit) begin
      case (op)
        sswe_pkg::OP_TICK: begin
          if (play_flag) begin
            if (tick_counter >= tempo) begin
              tick_counter <= 8'd0;
              current_step <= step_after;
              if (cell_data == 8'd0) begin
                tone_on <= 1'b0;
              end else begin
                tone_on <= 1'b1;
                period_reg <= cell_data;
              end
            end else begin
              tick_counter <= tick_counter + 8'd1;
            end
          end
        end
        sswe_pkg::OP_UP: begin
          if (cursor_row_reg != 2'd0) cursor_row_reg <= cursor_row_reg - 2'd1;
        end
        sswe_pkg::OP_DOWN: begin
          if (cursor_row_reg < 2'(sswe_pkg::PITCH_ROWS - 1)) begin
            cursor_row_reg <= cursor_row_reg + 2'd1;
          end
        end
        sswe_pkg::OP_LEFT: begin
          if (cursor_col_reg != 5'd0) cursor_col_reg <= cursor_col_reg - 5'd1;
        end
        sswe_pkg::OP_RIGHT: begin
          if (cursor_col_reg < 5'(sswe_pkg::STEPS - 1)) begin
            cursor_col_reg <= cursor_col_reg + 5'd1;
          end
        end
        sswe_pkg::OP_TOGGLE: begin
          cell_valid[cursor_col_reg[AW-1:0]] <= 1'b1;
        end
        sswe_pkg::OP_PLAY: begin
          play_flag <= !play_flag;
          tone_on <= !play_flag;
        end
        sswe_pkg::OP_CLEAR: begin
          cell_valid <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // result beat flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.out_full = out_valid && !out_ready;

  assign tone_enable = tone_on;
  assign tone_period = period_reg;
  assign tone_duty = period_reg[7:1];
  assign step_index = current_step;
  assign cursor_column = cursor_col_reg;
  assign cursor_row = cursor_row_reg;
  assign is_playing = play_flag;

endmodule

>>> design/step_sequencer_with_editor_core.sv
// Looping step sequencer with a grid editor. Each accepted beat on item is an operation (tick,
// cursor move, note toggle, play/pause or clear) and gives exactly one beat on result with the
// tone settings, the sounding step and the cursor after that operation. An item is accepted in
// the idle cycle, its step cell is read in the next cycle (registered read of the step cell
// memory) and the update is made in the execute state once no earlier result waits. No new
// item is accepted before the previous one is done; the next item is accepted while a result
// still waits, and an item finishes only once the previous result has been taken. Clear resets
// all per-cell valid bits at once; there is no clearing pass after reset. Pitch registers 0 to
// 3 are written on cfg; the user is to write them only while the block is idle, which the block
// itself does not enforce. cfg is always ready and writes beyond index 3 are dropped.
module step_sequencer_with_editor_core (
  input logic       clk,
  input logic       rst,
  sswe_in_if.sink   item,
  sswe_out_if.source result,
  sswe_cfg_if.sink  cfg
);

  sswe_pkg::cmd_t    cmd;
  sswe_pkg::status_t status;

  assign cfg.ready = 1'b1;

  sswe_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(item.valid),
    .in_ready(item.ready),
    .status  (status),
    .cmd     (cmd)
  );

  sswe_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .in_operation (item.operation),
    .in_tempo     (item.tempo),
    .cfg_valid    (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .tone_enable  (result.tone_enable),
    .tone_period  (result.tone_period),
    .tone_duty    (result.tone_duty),
    .step_index   (result.step_index),
    .cursor_column(result.cursor_column),
    .cursor_row   (result.cursor_row),
    .is_playing   (result.is_playing)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> !item.ready)
    else $error("item accepted while previous item still in work");

  a_result_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(cmd.commit))
    else $error("result beat raised without an update");

  a_no_commit_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(result.valid && !result.ready))
    else $error("update while result beat still waiting");

  a_indices_in_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.step_index < 5'(sswe_pkg::STEPS))
                  && (result.cursor_column < 5'(sswe_pkg::STEPS)))
    else $error("step or cursor column out of range");
`endif

endmodule

>>> dv/step_sequencer_with_editor_core_tb.sv
module step_sequencer_with_editor_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] REG_PITCH_ROW_0 = 8'd0;
  localparam logic [7:0] REG_PITCH_ROW_3 = 8'd3;
  localparam logic [7:0] REG_FIRST_UNUSED = 8'd4;
  localparam logic [7:0] REG_LAST_UNUSED = 8'd255;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 1250;

  typedef struct packed {
    logic       tone_enable;
    logic [7:0] tone_period;
    logic [6:0] tone_duty;
    logic [4:0] step_index;
    logic [4:0] cursor_column;
    logic [1:0] cursor_row;
    logic       is_playing;
  } tone_status_t;

  logic clk;
  logic rst;

  sswe_in_if  item_if ();
  sswe_out_if result_if ();
  sswe_cfg_if cfg_if ();

  step_sequencer_with_editor_core u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  // mirror of the sequencer
  logic [7:0] pitch_of_row [sswe_pkg::PITCH_ROWS];
  logic [7:0] seq_cells [sswe_pkg::STEPS];
  logic [4:0] seq_step;
  logic [7:0] seq_ticks;
  logic [4:0] seq_col;
  logic [1:0] seq_row;
  logic       seq_playing;
  logic       seq_tone_on;
  logic [7:0] seq_period;

  tone_status_t expected_tone_q [$];

  int  fail_cnt;
  int  cycle_cnt;
  bit  tx_idle;
  bit  rx_idle;
  bit  rx_hold_req;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("** step_sequencer_with_editor_core: FAILED **");
      $finish;
    end
  end

  function automatic void reset_sequencer_image();
    for (int r = 0; r < sswe_pkg::PITCH_ROWS; r++) pitch_of_row[r] = sswe_pkg::PITCH_RESET[r];
    for (int s = 0; s < sswe_pkg::STEPS; s++) seq_cells[s] = '0;
    seq_step = '0;
    seq_ticks = '0;
    seq_col = '0;
    seq_row = '0;
    seq_playing = 1'b1;
    seq_tone_on = 1'b0;
    seq_period = '0;
  endfunction

  function automatic tone_status_t advance_sequencer(input sswe_pkg::op_t op,
                                                     input logic [7:0] tempo);
    logic [7:0]   old_ticks;
    tone_status_t s;
    case (op)
      sswe_pkg::OP_TICK: begin
        if (seq_playing) begin
          old_ticks = seq_ticks;
          seq_ticks = old_ticks + 8'd1;
          if (old_ticks >= tempo) begin
            seq_ticks = '0;
            seq_step = 5'((int'(seq_step) + 1) % sswe_pkg::STEPS);
            if (seq_cells[seq_step] == 8'd0) begin
              seq_tone_on = 1'b0;
            end else begin
              seq_tone_on = 1'b1;
              seq_period = seq_cells[seq_step];
            end
          end
        end
      end
      sswe_pkg::OP_UP: begin
        if (seq_row > 0) seq_row = seq_row - 2'd1;
      end
      sswe_pkg::OP_DOWN: begin
        if (int'(seq_row) < sswe_pkg::PITCH_ROWS - 1) seq_row = seq_row + 2'd1;
      end
      sswe_pkg::OP_LEFT: begin
        if (seq_col > 0) seq_col = seq_col - 5'd1;
      end
      sswe_pkg::OP_RIGHT: begin
        if (int'(seq_col) < sswe_pkg::STEPS - 1) seq_col = seq_col + 5'd1;
      end
      sswe_pkg::OP_TOGGLE: begin
        if (seq_cells[seq_col] == pitch_of_row[seq_row]) seq_cells[seq_col] = '0;
        else seq_cells[seq_col] = pitch_of_row[seq_row];
      end
      sswe_pkg::OP_PLAY: begin
        seq_playing = ~seq_playing;
        seq_tone_on = seq_playing;
      end
      default: begin
        for (int c = 0; c < sswe_pkg::STEPS; c++) seq_cells[c] = '0;
      end
    endcase
    s.tone_enable = seq_tone_on;
    s.tone_period = seq_period;
    s.tone_duty = seq_period[7:1];
    s.step_index = seq_step;
    s.cursor_column = seq_col;
    s.cursor_row = seq_row;
    s.is_playing = seq_playing;
    return s;
  endfunction

  function automatic string fmt_status(input tone_status_t s);
    return $sformatf("en=%0d per=%0d duty=%0d step=%0d col=%0d row=%0d play=%0d",
                     s.tone_enable, s.tone_period, s.tone_duty, s.step_index,
                     s.cursor_column, s.cursor_row, s.is_playing);
  endfunction

  // result checker
  always @(posedge clk) begin
    tone_status_t got;
    tone_status_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      got.tone_enable = result_if.tone_enable;
      got.tone_period = result_if.tone_period;
      got.tone_duty = result_if.tone_duty;
      got.step_index = result_if.step_index;
      got.cursor_column = result_if.cursor_column;
      got.cursor_row = result_if.cursor_row;
      got.is_playing = result_if.is_playing;
      if (expected_tone_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("unexpected beat: %s", fmt_status(got));
      end else begin
        want = expected_tone_q.pop_front();
        if (got.tone_enable !== want.tone_enable || got.tone_period !== want.tone_period ||
            got.tone_duty !== want.tone_duty || got.step_index !== want.step_index ||
            got.cursor_column !== want.cursor_column || got.cursor_row !== want.cursor_row ||
            got.is_playing !== want.is_playing) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("mismatch at %0t", $realtime);
            $display("  expected: %s", fmt_status(want));
            $display("  actual:   %s", fmt_status(got));
          end
        end
      end
    end
  end

  // result receiver
  initial begin
    int stall;
    result_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        result_if.ready <= 1'b0;
        for (int c = 0; c < HOLD_OFF_CYCLES; c++) @(posedge clk);
        rx_hold_req = 1'b0;
      end
      stall = rx_idle ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk); while (!result_if.valid);
    end
  end

  task automatic send_item(input sswe_pkg::op_t op, input logic [7:0] tempo);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_if.valid <= 1'b1;
    item_if.operation <= op;
    item_if.tempo <= tempo;
    do @(posedge clk); while (!item_if.ready);
    expected_tone_q.push_back(advance_sequencer(op, tempo));
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx <= REG_PITCH_ROW_3) pitch_of_row[idx - REG_PITCH_ROW_0] = value;
  endtask

  task automatic end_reg_writes();
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_block();
    item_if.valid <= 1'b0;
    while (expected_tone_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_random_item();
    int   pick;
    int   span;
    sswe_pkg::op_t op;
    logic [7:0] tempo;
    pick = $urandom_range(0, 99);
    if (pick < 45) op = sswe_pkg::OP_TICK;
    else if (pick < 53) op = sswe_pkg::OP_UP;
    else if (pick < 61) op = sswe_pkg::OP_DOWN;
    else if (pick < 69) op = sswe_pkg::OP_LEFT;
    else if (pick < 77) op = sswe_pkg::OP_RIGHT;
    else if (pick < 92) op = sswe_pkg::OP_TOGGLE;
    else if (pick < 97) op = sswe_pkg::OP_PLAY;
    else op = sswe_pkg::OP_CLEAR;
    if (!seq_playing && $urandom_range(0, 3) == 0) op = sswe_pkg::OP_PLAY;
    span = $urandom_range(0, 99);
    if (span < 70) tempo = 8'($urandom_range(0, 3));
    else if (span < 95) tempo = 8'($urandom_range(0, 15));
    else tempo = 8'($urandom_range(0, 255));
    send_item(op, tempo);
  endtask

  task automatic load_pitches(input logic [7:0] p0, input logic [7:0] p1,
                              input logic [7:0] p2, input logic [7:0] p3);
    drain_block();
    write_reg(REG_PITCH_ROW_0, p0);
    write_reg(REG_PITCH_ROW_0 + 8'd1, p1);
    write_reg(REG_PITCH_ROW_0 + 8'd2, p2);
    write_reg(REG_PITCH_ROW_3, p3);
    write_reg(REG_FIRST_UNUSED, 8'($urandom_range(0, 255)));
    write_reg(REG_LAST_UNUSED, 8'($urandom_range(0, 255)));
    end_reg_writes();
  endtask

  task automatic test_directed_ops();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_item(sswe_pkg::OP_TICK, 8'd0);
    send_item(sswe_pkg::OP_UP, 8'd255);
    send_item(sswe_pkg::OP_LEFT, 8'd0);
    send_item(sswe_pkg::OP_RIGHT, 8'd0);
    send_item(sswe_pkg::OP_RIGHT, 8'd0);
    send_item(sswe_pkg::OP_TOGGLE, 8'd0);
    send_item(sswe_pkg::OP_DOWN, 8'd0);
    send_item(sswe_pkg::OP_RIGHT, 8'd0);
    send_item(sswe_pkg::OP_TOGGLE, 8'd0);
    send_item(sswe_pkg::OP_TOGGLE, 8'd0);
    send_item(sswe_pkg::OP_TOGGLE, 8'd0);
    send_item(sswe_pkg::OP_TICK, 8'd0);
    send_item(sswe_pkg::OP_TICK, 8'd1);
    send_item(sswe_pkg::OP_TICK, 8'd1);
    send_item(sswe_pkg::OP_TICK, 8'd0);
    send_item(sswe_pkg::OP_PLAY, 8'd0);
    send_item(sswe_pkg::OP_TICK, 8'd0);
    send_item(sswe_pkg::OP_PLAY, 8'd0);
    send_item(sswe_pkg::OP_DOWN, 8'd0);
    send_item(sswe_pkg::OP_DOWN, 8'd0);
    send_item(sswe_pkg::OP_DOWN, 8'd0);
    send_item(sswe_pkg::OP_LEFT, 8'd0);
    send_item(sswe_pkg::OP_TOGGLE, 8'd0);
    send_item(sswe_pkg::OP_CLEAR, 8'd0);
    send_item(sswe_pkg::OP_TICK, 8'd255);
  endtask

  task automatic test_cursor_edges();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    for (int i = 0; i < sswe_pkg::STEPS + 2; i++) begin
      send_item(sswe_pkg::OP_RIGHT, 8'($urandom_range(0, 255)));
    end
    send_item(sswe_pkg::OP_TOGGLE, 8'd0);
    for (int i = 0; i < sswe_pkg::STEPS + 2; i++) send_item(sswe_pkg::OP_LEFT, 8'd0);
    for (int i = 0; i < sswe_pkg::PITCH_ROWS + 1; i++) send_item(sswe_pkg::OP_UP, 8'd0);
  endtask

  task automatic test_counter_top();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    if (!seq_playing) send_item(sswe_pkg::OP_PLAY, 8'd0);
    send_item(sswe_pkg::OP_TOGGLE, 8'd0);
    for (int i = 0; i < 260; i++) send_item(sswe_pkg::OP_TICK, 8'd255);
    for (int i = 0; i < 250; i++) send_item(sswe_pkg::OP_TICK, 8'd254);
    send_item(sswe_pkg::OP_TICK, 8'd0);
  endtask

  task automatic test_pitch_settings();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    load_pitches(8'd0, 8'd1, 8'd255, 8'd128);
    for (int i = 0; i < 60; i++) send_random_item();
    load_pitches(8'd255, 8'd255, 8'd1, 8'd1);
    for (int i = 0; i < 60; i++) send_random_item();
    load_pitches(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
    for (int i = 0; i < 60; i++) send_random_item();
    load_pitches(sswe_pkg::PITCH_RESET[0], sswe_pkg::PITCH_RESET[1],
                 sswe_pkg::PITCH_RESET[2], sswe_pkg::PITCH_RESET[3]);
  endtask

  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_random_item();
    item_if.valid <= 1'b0;
    while (expected_tone_q.size() != 0) @(posedge clk);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    for (int i = 0; i < 40; i++) send_random_item();
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 500 == 499) begin
        load_pitches(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                     8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
      end
      if (i % 250 == 0) begin
        tx_idle = ((i / 250) % 4) inside {0, 1};
        rx_idle = ((i / 250) % 4) inside {0, 2};
      end
      send_random_item();
    end
  endtask

  initial begin
    rst <= 1'b1;
    item_if.valid <= 1'b0;
    item_if.operation <= sswe_pkg::OP_TICK;
    item_if.tempo <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data <= '0;
    fail_cnt = 0;
    cycle_cnt = 0;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold_req = 1'b0;
    reset_sequencer_image();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed_ops();
    test_cursor_edges();
    test_counter_top();
    test_pitch_settings();
    test_backpressure();
    test_random_mix();
    drain_block();
    if (fail_cnt == 0) begin
      $display("** step_sequencer_with_editor_core: PASSED **");
    end else begin
      $display("** step_sequencer_with_editor_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/sswe_pkg.sv
design/sswe_if.sv
design/sswe_ram.sv
design/sswe_ctrl.sv
design/sswe_dp.sv
design/step_sequencer_with_editor_core.sv
dv/step_sequencer_with_editor_core_tb.sv
